// ===== sv/base64_stream_decoder_unit_assert.svh =====
// assertion macros shared by the base64 stream decoder modules
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent checked in the same cycle as the antecedent
`define B64SD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64sd assertion failed");

// consequent checked in the cycle after the antecedent
`define B64SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64sd assertion failed");

`else

`define B64SD_ASSERT_SAME(label, ante, cons)
`define B64SD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/b64sd_pkg.sv =====
// types, character constants and sextet lookup for the base64 stream decoder
`timescale 1ns / 1ps

package b64sd_pkg;

  // most result words one input word can cause
  localparam int unsigned MAX_RES = 3;

  // character codes bounding the alphabet ranges
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  // sextet values at the start of each range
  localparam logic [7:0] LOWER_BASE  = 8'd26;
  localparam logic [7:0] DIGIT_BASE  = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       msg_end;
  } res_t;

  // all result words caused by one input word
  typedef struct packed {
    logic [1:0]               count;
    res_t [MAX_RES-1:0]       res;
  } group_t;

  // decoded character
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // map a character to its sextet, ok low for padding and non-alphabet bytes
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = '0;
    priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      s.value = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      s.value = 6'(c - CH_LOWER_A + LOWER_BASE);
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      s.value = 6'(c - CH_DIGIT_0 + DIGIT_BASE);
    end else if (c == CH_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CH_SLASH) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== sv/b64sd_decode.sv =====
// character decode, sextet collection and result group generation
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_assert.svh"

module b64sd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_char,
  input  logic              char_present,
  input  logic              msg_last,
  output b64sd_pkg::group_t grp
);

  logic [17:0]       sextet_buffer;
  logic [17:0]       sextet_buffer_next;
  logic [1:0]        sextet_count;
  logic [1:0]        sextet_count_next;
  logic              halted;
  logic              halted_next;
  logic [17:0]       buf_after;
  logic [1:0]        cnt_after;
  logic              group_full;
  logic [23:0]       word;
  b64sd_pkg::sextet_t sx;

  // next state and result group for the offered word
  always_comb begin
    sx         = b64sd_pkg::sextet_of(in_char);
    buf_after  = sextet_buffer;
    cnt_after  = sextet_count;
    halted_next = halted;
    group_full = 1'b0;
    word       = {sextet_buffer, sx.value};
    grp        = '0;

    // character step
    if (char_present && !halted) begin
      if (!sx.ok) begin
        halted_next = 1'b1;
      end else if (sextet_count == 2'd3) begin
        group_full = 1'b1;
        grp.count  = 2'd3;
        grp.res[0].out_byte   = word[23:16];
        grp.res[0].byte_valid = 1'b1;
        grp.res[1].out_byte   = word[15:8];
        grp.res[1].byte_valid = 1'b1;
        grp.res[2].out_byte   = word[7:0];
        grp.res[2].byte_valid = 1'b1;
        buf_after = '0;
        cnt_after = 2'd0;
      end else begin
        buf_after = {sextet_buffer[11:0], sx.value};
        cnt_after = sextet_count + 2'd1;
      end
    end

    sextet_buffer_next = buf_after;
    sextet_count_next  = cnt_after;

    // message end flush
    if (msg_last) begin
      if (!group_full) begin
        unique case (cnt_after)
          2'd2: begin
            grp.count = 2'd1;
            grp.res[0].out_byte   = buf_after[11:4];
            grp.res[0].byte_valid = 1'b1;
          end
          2'd3: begin
            grp.count = 2'd2;
            grp.res[0].out_byte   = buf_after[17:10];
            grp.res[0].byte_valid = 1'b1;
            grp.res[1].out_byte   = buf_after[9:2];
            grp.res[1].byte_valid = 1'b1;
          end
          default: begin
            grp.count = 2'd1;
          end
        endcase
      end
      sextet_buffer_next = '0;
      sextet_count_next  = 2'd0;
      halted_next        = 1'b0;
    end

    // end markers on the final word of the group
    for (int k = 0; k < int'(b64sd_pkg::MAX_RES); k++) begin
      grp.res[k].run_last = (grp.count == 2'(k + 1));
      grp.res[k].msg_end  = msg_last && (grp.count == 2'(k + 1));
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer <= '0;
      sextet_count  <= 2'd0;
      halted        <= 1'b0;
    end else if (accept) begin
      sextet_buffer <= sextet_buffer_next;
      sextet_count  <= sextet_count_next;
      halted        <= halted_next;
    end
  end

  `B64SD_ASSERT_NEXT(a_end_clears, accept && msg_last, sextet_count == 2'd0 && !halted)
  `B64SD_ASSERT_SAME(a_end_has_result, accept && msg_last, grp.count != 2'd0)
  `B64SD_ASSERT_NEXT(a_empty_holds, accept && !char_present && !msg_last, $stable(sextet_buffer) && $stable(sextet_count) && $stable(halted))

endmodule

// ===== sv/b64sd_out_queue.sv =====
// four-entry queue: a group in per cycle if room, one word out per cycle if ready
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_assert.svh"

module b64sd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64sd_pkg::group_t grp,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output b64sd_pkg::res_t   head_res
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64sd_pkg::res_t        entries [DEPTH];
  b64sd_pkg::res_t        entries_next [DEPTH];
  logic [DEPTH-1:0]       wr_en;
  logic [PTR_W-1:0]       offs [DEPTH];
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_after_pop;
  logic [CNT_W-1:0]       push_n;
  logic                   pop;

  // handshake and room for a full group
  assign out_valid       = (count != '0);
  assign pop             = out_valid && out_ready;
  assign count_after_pop = count - CNT_W'(pop);
  assign space           = (count_after_pop <= CNT_W'(DEPTH - b64sd_pkg::MAX_RES));
  assign push_n          = push ? CNT_W'(grp.count) : '0;
  assign head_res        = entries[head];

  // scatter the group into the slots after the tail
  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      offs[i]         = PTR_W'(i) - tail;
      wr_en[i]        = push && (CNT_W'(offs[i]) < CNT_W'(grp.count));
      entries_next[i] = entries[i];
      if (wr_en[i]) begin
        unique case (offs[i])
          2'd0:    entries_next[i] = grp.res[0];
          2'd1:    entries_next[i] = grp.res[1];
          default: entries_next[i] = grp.res[2];
        endcase
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      entries[i] <= entries_next[i];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      tail  <= tail + PTR_W'(push_n);
      count <= count_after_pop + push_n;
    end
  end

  `B64SD_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `B64SD_ASSERT_SAME(a_push_has_room, push, space)
  `B64SD_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 1'b1)

endmodule

// ===== sv/base64_stream_decoder_unit.sv =====
// top level of the streaming base64 decoder
`timescale 1ns / 1ps
// Streaming base64 decoder. The s_ channel takes one text character per word
// (s_tuser marks a real character, s_tlast closes the message); the m_
// channel gives one decoded byte per word. An input word yields zero to three
// output words: three when it completes a group of four sextets, and at
// message end the leftover bytes or a bare end marker (m_tuser[0] low).
// m_tuser[1] flags the last output word caused by an input word; m_tlast
// flags the last output word of the message.
// Output words reach m_ behind any words already queued. The decode logic
// takes one input word per cycle while s_tready is high; the four-entry
// output queue sends one word per cycle while m_tready is high and accepts
// an input only when it has room for three more words, so s_tready drops
// for one cycle after a three-byte group while m_tready is high, and input
// keeps flowing while at most one word waits. A stalled receiver holds the
// queue head on m_ and s_tready falls once the queue cannot take another
// group. Reset clears the sextet buffer, the halt flag and the queue.

module base64_stream_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tuser,   // [0] char_present
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] run_last
  output logic       m_tlast
);

  b64sd_pkg::group_t grp;
  b64sd_pkg::res_t   head_res;
  logic              accept;
  logic              space;

  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  // character decode and group generation
  b64sd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_char      (s_tdata),
    .char_present (s_tuser),
    .msg_last     (s_tlast),
    .grp          (grp)
  );

  // result queue
  b64sd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .grp       (grp),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head_res  (head_res)
  );

  // output word
  assign m_tdata = head_res.out_byte;
  assign m_tuser = {head_res.run_last, head_res.byte_valid};
  assign m_tlast = head_res.msg_end;

endmodule
